/* hw/rtl/assert_macros.svh */
// Assertion helpers for the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, inactive while reset is high.
`define MAPA_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("mapa assertion failed");

// Clocked assertion that also holds across reset.
`define MAPA_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("mapa assertion failed");

`endif

/* hw/rtl/mapa_pkg.sv */
package mapa_pkg;

   localparam int WINDOW_MAX  = 64;
   localparam int SAMPLE_BITS = 24;

   localparam int SAMPLE_FIELD_BITS = 24;
   localparam int WSUM_BITS         = 30;
   localparam int WLEN_BITS         = 7;
   localparam int THR_BITS          = 24;
   localparam int CSR_DATA_BITS     = 24;
   localparam int CSR_INDEX_BITS    = 1;

   localparam int PTR_BITS   = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
   localparam int FILL_BITS  = $clog2(WINDOW_MAX + 1);
   localparam int OFS_BITS   = FILL_BITS + 1;
   localparam int SUM_BITS   = SAMPLE_BITS + $clog2(WINDOW_MAX);
   localparam int LIMIT_BITS = THR_BITS + FILL_BITS;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_WINDOW_LENGTH = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BAD_THRESHOLD = 1'd1;

   localparam logic [WLEN_BITS-1:0] WLEN_RESET = 7'd10;
   localparam logic [THR_BITS-1:0]  THR_RESET  = 24'd0;

   typedef struct packed {
      logic [SAMPLE_FIELD_BITS-1:0] sample;
      logic                         new_series;
   } req_type;

   typedef struct packed {
      logic [WSUM_BITS-1:0] window_sum;
      logic                 mean_over;
      logic                 series_bad;
   } rsp_type;

endpackage

/* hw/rtl/moving_average_persistence_alarm.sv */
// channel   direction  handshake              payload
// req       in         req_valid / req_ready  req_payload  (sample, new_series)
// rsp       out        rsp_valid / rsp_ready  rsp_payload  (window_sum, mean_over, series_bad)
// csr       in         csr_we                 csr_index, csr_wdata
//
// One request per cycle unless rsp stalls; its result passes the compute and rsp registers.
// The window ring is one RAM: the oldest sample is read and the new one written at accept,
// the sum and threshold compare run in the following stage.
// Synchronous active-high reset clears pointers, fill, sum, flags and config to defaults.
// A stalled response holds; one more request can wait in the compute stage behind it.
module moving_average_persistence_alarm
   import mapa_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  req_type                   req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output rsp_type                   rsp_payload,
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   logic [SAMPLE_BITS-1:0] mem [WINDOW_MAX];

   logic [WLEN_BITS-1:0]   wlen_ff;
   logic [THR_BITS-1:0]    thr_ff;
   logic [LIMIT_BITS-1:0]  limit_ff;

   logic [PTR_BITS-1:0]    wp_ff;
   logic [FILL_BITS-1:0]   fill_ff;
   logic [SUM_BITS-1:0]    sum_ff;
   logic                   prev_ff;
   logic                   bad_ff;

   logic                   b_valid_ff;
   logic [SAMPLE_BITS-1:0] b_sample_ff;
   logic                   b_remove_ff;
   logic                   b_clear_ff;
   logic [SAMPLE_BITS-1:0] rd_ff;

   logic                   rsp_valid_ff;
   rsp_type                rsp_payload_ff;

   logic [FILL_BITS-1:0]   len_eff;
   logic [FILL_BITS-1:0]   fill_cur;
   logic [PTR_BITS-1:0]    wp_cur;
   logic [PTR_BITS-1:0]    wp_in;
   logic [FILL_BITS-1:0]   fill_in;
   logic                   remove;
   logic [OFS_BITS-1:0]    ofs;
   logic [PTR_BITS-1:0]    oldest;
   logic [63:0]            samp_wide;
   logic [SAMPLE_BITS-1:0] sample_cut;
   logic                   req_acc;
   logic                   b_go;

   logic [SUM_BITS:0]      sum_wide_in;
   logic [SUM_BITS-1:0]    sum_in;
   logic [63:0]            sum_ext;
   logic                   over_in;
   logic                   prev_cur;
   logic                   bad_in;
   rsp_type                rsp_in;

   always_comb begin
      if (wlen_ff == '0) begin
         len_eff = FILL_BITS'(1);
      end else if (32'(wlen_ff) > WINDOW_MAX) begin
         len_eff = FILL_BITS'(WINDOW_MAX);
      end else begin
         len_eff = FILL_BITS'(wlen_ff);
      end
   end

   always_comb begin
      fill_cur   = req_payload.new_series ? '0 : fill_ff;
      wp_cur     = req_payload.new_series ? '0 : wp_ff;
      remove     = fill_cur >= len_eff;
      fill_in    = remove ? fill_cur : fill_cur + FILL_BITS'(1);
      wp_in      = (32'(wp_cur) == WINDOW_MAX - 1) ? '0 : wp_cur + PTR_BITS'(1);
      ofs        = OFS_BITS'(wp_cur) + OFS_BITS'(WINDOW_MAX) - OFS_BITS'(fill_cur);
      if (32'(ofs) >= WINDOW_MAX) begin
         ofs = ofs - OFS_BITS'(WINDOW_MAX);
      end
      oldest     = ofs[PTR_BITS-1:0];
      samp_wide  = 64'(req_payload.sample);
      sample_cut = samp_wide[SAMPLE_BITS-1:0];
   end

   assign b_go      = !rsp_valid_ff || rsp_ready;
   assign req_ready = !b_valid_ff || b_go;
   assign req_acc   = req_valid && req_ready;

   always_comb begin
      sum_wide_in = (b_clear_ff ? '0 : (SUM_BITS + 1)'(sum_ff))
                    + (SUM_BITS + 1)'(b_sample_ff)
                    - (b_remove_ff ? (SUM_BITS + 1)'(rd_ff) : '0);
      sum_in      = sum_wide_in[SUM_BITS-1:0];
      sum_ext     = 64'(sum_in);
      over_in     = sum_ext > 64'(limit_ff);
      prev_cur    = b_clear_ff ? 1'b0 : prev_ff;
      bad_in      = (b_clear_ff ? 1'b0 : bad_ff) || (over_in && prev_cur);
      rsp_in.window_sum = sum_ext[WSUM_BITS-1:0];
      rsp_in.mean_over  = over_in;
      rsp_in.series_bad = bad_in;
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         rd_ff       <= mem[oldest];
         mem[wp_cur] <= sample_cut;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wlen_ff      <= WLEN_RESET;
         thr_ff       <= THR_RESET;
         limit_ff     <= '0;
         wp_ff        <= '0;
         fill_ff      <= '0;
         sum_ff       <= '0;
         prev_ff      <= 1'b0;
         bad_ff       <= 1'b0;
         b_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         limit_ff <= LIMIT_BITS'(thr_ff) * LIMIT_BITS'(len_eff);
         if (csr_we) begin
            case (csr_index)
               CSR_WINDOW_LENGTH: wlen_ff <= csr_wdata[WLEN_BITS-1:0];
               CSR_BAD_THRESHOLD: thr_ff  <= csr_wdata[THR_BITS-1:0];
               default: ;
            endcase
         end
         if (req_acc) begin
            wp_ff      <= wp_in;
            fill_ff    <= fill_in;
            b_valid_ff <= 1'b1;
         end else if (b_go) begin
            b_valid_ff <= 1'b0;
         end
         if (b_valid_ff && b_go) begin
            sum_ff       <= sum_in;
            prev_ff      <= over_in;
            bad_ff       <= bad_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         b_sample_ff <= sample_cut;
         b_remove_ff <= remove;
         b_clear_ff  <= req_payload.new_series;
      end
      if (b_valid_ff && b_go) begin
         rsp_payload_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

/* hw/rtl/mapa_checker.sv */
`include "assert_macros.svh"

module mapa_checker
   import mapa_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_payload
);

   // no response may come out of reset
   `MAPA_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid)

   // an empty response slot always drains the compute stage
   `MAPA_ASSERT(a_ready_when_empty, clock, reset, !rsp_valid |-> req_ready)

   // a response that has not yet been taken keeps its request's result
   `MAPA_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))

endmodule

bind moving_average_persistence_alarm mapa_checker u_mapa_checker (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);
